// ===== design/flash_eeprom_emulation_defines.svh =====
// ----------------------------------------------------------------------------
// Flash EEPROM emulation assertion macros
// Shared macros for the concurrent checks of the emulation block.
// ----------------------------------------------------------------------------
`ifndef FLASH_EEPROM_EMULATION_DEFINES_SVH
`define FLASH_EEPROM_EMULATION_DEFINES_SVH

// A check that is switched off while reset is high.
`define FEE_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error(msg);

// A check that also holds across reset.
`define FEE_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== design/fee_pkg.sv =====
// ----------------------------------------------------------------------------
// Flash EEPROM emulation package
// Field widths, flash word codes, result status codes and controller states.
// ----------------------------------------------------------------------------
package fee_pkg;

   localparam int ADDR_W = 9;
   localparam int DATA_W = 16;
   localparam int WORD_W = 32;

   localparam logic [WORD_W-1:0] WORD_ERASED = 32'hFFFF_FFFF;
   localparam logic [WORD_W-1:0] HDR_RECEIVE = 32'hFFFF_EEEE;
   localparam logic [WORD_W-1:0] HDR_VALID   = 32'hFFFF_0000;

   typedef logic [1:0] status_type;

   localparam status_type STAT_DONE      = 2'd0;
   localparam status_type STAT_NOT_FOUND = 2'd1;
   localparam status_type STAT_FULL      = 2'd2;

   typedef enum logic [3:0] {
      ST_FORMAT,
      ST_IDLE,
      ST_RD_MAP,
      ST_RD_FLASH,
      ST_CNT_RD,
      ST_CNT_CHK,
      ST_RX_HDR,
      ST_NEW_ENTRY,
      ST_CP_RD,
      ST_CP_CHK,
      ST_CP_WR,
      ST_ERASE,
      ST_VALID_HDR,
      ST_DONE
   } state_type;

endpackage

// ===== design/flash_eeprom_emulation.sv =====
// ----------------------------------------------------------------------------
// Flash EEPROM emulation
// Sixteen-bit variables kept as appended entries in two flash pages, with
// compaction into the other page when the active page fills up.
// ----------------------------------------------------------------------------
// The request channel carries one read or write of a variable per beat; the
// response channel returns one beat per request with the read data and a
// status. A request is taken only while the controller is idle; a finished
// response waits in an output register, so the next request can be taken
// while the receiver stalls the previous response.
// A read does a map lookup, then one flash read; when the variable has no map
// entry it answers after the lookup alone. A write that fits in the active
// page and an out-of-range address are answered straight from idle. The
// controller returns to idle as the response is loaded into the output
// register, so a new request can be taken once the response is loaded.
// A write into a full page first counts the live variables; if they and the
// new value do not fit beside the page header it answers with the full status,
// else it compacts: it copies each live variable into the other page and
// erases the old page, every step through the single port of the flash memory.
// After reset the block formats the store, one flash word and one map entry
// per cycle, and holds req_stall high during that sweep.
// ----------------------------------------------------------------------------
`include "flash_eeprom_emulation_defines.svh"

module flash_eeprom_emulation #(
   parameter int PAGE_WORDS = 1024,
   parameter int NUM_VARS   = 272
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_stall,
   input  logic                       req_func,
   input  logic [fee_pkg::ADDR_W-1:0] req_var_addr,
   input  logic [fee_pkg::DATA_W-1:0] req_write_data,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output logic [fee_pkg::DATA_W-1:0] rsp_read_data,
   output fee_pkg::status_type        rsp_status
);

   import fee_pkg::*;

   localparam int SLOT_W      = $clog2(PAGE_WORDS);
   localparam int FLASH_DEPTH = 2 * PAGE_WORDS;
   localparam int FA_W        = $clog2(FLASH_DEPTH);
   localparam int VAR_W       = $clog2(NUM_VARS);
   localparam int SWEEP       = (FLASH_DEPTH > NUM_VARS) ? FLASH_DEPTH : NUM_VARS;
   localparam int CNT_W       = $clog2(SWEEP + 1);
   localparam int NEED_W      = $clog2(NUM_VARS + 1);

   state_type state_ff, state_in;

   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic [NEED_W-1:0] need_ff, need_in;
   logic [ADDR_W-1:0] addr_ff, addr_in;
   logic [DATA_W-1:0] data_ff, data_in;
   logic              act_ff, act_in;
   logic [SLOT_W-1:0] slot_ff, slot_in;
   logic [DATA_W-1:0] res_data_ff, res_data_in;
   status_type        res_status_ff, res_status_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [DATA_W-1:0] rsp_data_ff, rsp_data_in;
   status_type        rsp_status_ff, rsp_status_in;

   logic              fl_we;
   logic [FA_W-1:0]   fl_addr;
   logic [WORD_W-1:0] fl_wdata, fl_rdata;
   logic              mp_we;
   logic [VAR_W-1:0]  mp_addr;
   logic [SLOT_W-1:0] mp_wdata, mp_rdata;

   logic              req_take, in_range, map_hit, cnt_is_a, cnt_last_var;
   logic              need_full, rsp_load;
   logic [NEED_W-1:0] need_inc;
   logic [SLOT_W-1:0] slot_inc;
   logic [VAR_W-1:0]  cnt_var;
   logic [FA_W-1:0]   act_base, oth_base;

   fee_ram #(.WIDTH(WORD_W), .DEPTH(FLASH_DEPTH)) u_flash (
      .clock   (clock),
      .wr_en   (fl_we),
      .addr    (fl_addr),
      .wr_data (fl_wdata),
      .rd_data (fl_rdata)
   );

   fee_ram #(.WIDTH(SLOT_W), .DEPTH(NUM_VARS)) u_map (
      .clock   (clock),
      .wr_en   (mp_we),
      .addr    (mp_addr),
      .wr_data (mp_wdata),
      .rd_data (mp_rdata)
   );

   assign req_stall     = (state_ff != ST_IDLE);
   assign req_take      = req_valid && !req_stall;
   assign in_range      = 32'(req_var_addr) < NUM_VARS;
   assign map_hit       = (mp_rdata != '0);
   assign cnt_var       = cnt_ff[VAR_W-1:0];
   assign cnt_is_a      = (32'(cnt_ff) == 32'(addr_ff));
   assign cnt_last_var  = (cnt_ff == CNT_W'(NUM_VARS - 1));
   assign need_inc      = NEED_W'(need_ff + NEED_W'(map_hit && !cnt_is_a));
   assign need_full     = 32'(need_inc) > (PAGE_WORDS - 1);
   assign slot_inc      = (32'(slot_ff) + 1 >= PAGE_WORDS) ? '0 : SLOT_W'(slot_ff + 1'b1);
   assign act_base      = act_ff ? FA_W'(PAGE_WORDS) : '0;
   assign oth_base      = act_ff ? '0 : FA_W'(PAGE_WORDS);
   assign rsp_load      = (state_ff == ST_DONE) && (!rsp_valid_ff || !rsp_stall);

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_read_data = rsp_data_ff;
   assign rsp_status    = rsp_status_ff;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_FORMAT: begin
            if (cnt_ff == CNT_W'(SWEEP - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_take) begin
               if (!in_range) begin
                  state_in = ST_DONE;
               end else if (!req_func) begin
                  state_in = ST_RD_MAP;
               end else if (slot_ff != '0) begin
                  state_in = ST_DONE;
               end else begin
                  state_in = ST_CNT_RD;
               end
            end
         end
         ST_RD_MAP:    state_in = map_hit ? ST_RD_FLASH : ST_DONE;
         ST_RD_FLASH:  state_in = ST_DONE;
         ST_CNT_RD:    state_in = ST_CNT_CHK;
         ST_CNT_CHK: begin
            if (!cnt_last_var) begin
               state_in = ST_CNT_RD;
            end else if (need_full) begin
               state_in = ST_DONE;
            end else begin
               state_in = ST_RX_HDR;
            end
         end
         ST_RX_HDR:    state_in = ST_NEW_ENTRY;
         ST_NEW_ENTRY: state_in = ST_CP_RD;
         ST_CP_RD:     state_in = ST_CP_CHK;
         ST_CP_CHK: begin
            if (map_hit && !cnt_is_a) begin
               state_in = ST_CP_WR;
            end else begin
               state_in = cnt_last_var ? ST_ERASE : ST_CP_RD;
            end
         end
         ST_CP_WR:     state_in = cnt_last_var ? ST_ERASE : ST_CP_RD;
         ST_ERASE: begin
            if (cnt_ff == CNT_W'(PAGE_WORDS - 1)) begin
               state_in = ST_VALID_HDR;
            end
         end
         ST_VALID_HDR: state_in = ST_DONE;
         ST_DONE: begin
            if (rsp_load) begin
               state_in = ST_IDLE;
            end
         end
         default:      state_in = ST_FORMAT;
      endcase
   end

   always_comb begin
      fl_we         = 1'b0;
      fl_addr       = act_base + FA_W'(slot_ff);
      fl_wdata      = WORD_ERASED;
      mp_we         = 1'b0;
      mp_addr       = cnt_var;
      mp_wdata      = '0;
      cnt_in        = cnt_ff;
      need_in       = need_ff;
      addr_in       = addr_ff;
      data_in       = data_ff;
      act_in        = act_ff;
      slot_in       = slot_ff;
      res_data_in   = res_data_ff;
      res_status_in = res_status_ff;
      rsp_data_in   = rsp_data_ff;
      rsp_status_in = rsp_status_ff;
      unique case (state_ff)
         ST_FORMAT: begin
            fl_we    = (32'(cnt_ff) < FLASH_DEPTH);
            fl_addr  = cnt_ff[FA_W-1:0];
            fl_wdata = (cnt_ff == '0) ? HDR_VALID : WORD_ERASED;
            mp_we    = (32'(cnt_ff) < NUM_VARS);
            cnt_in   = CNT_W'(cnt_ff + 1'b1);
         end
         ST_IDLE: begin
            res_data_in = '0;
            if (req_take) begin
               addr_in = req_var_addr;
               data_in = req_write_data;
               if (!in_range) begin
                  res_status_in = req_func ? STAT_DONE : STAT_NOT_FOUND;
               end else if (!req_func) begin
                  mp_addr = VAR_W'(req_var_addr);
               end else if (slot_ff != '0) begin
                  fl_we         = 1'b1;
                  fl_wdata      = {16'(req_var_addr), req_write_data};
                  mp_we         = 1'b1;
                  mp_addr       = VAR_W'(req_var_addr);
                  mp_wdata      = slot_ff;
                  slot_in       = slot_inc;
                  res_status_in = STAT_DONE;
               end else begin
                  cnt_in  = '0;
                  need_in = NEED_W'(1);
               end
            end
         end
         ST_RD_MAP: begin
            fl_addr       = act_base + FA_W'(mp_rdata);
            res_status_in = STAT_NOT_FOUND;
         end
         ST_RD_FLASH: begin
            res_data_in   = fl_rdata[DATA_W-1:0];
            res_status_in = STAT_DONE;
         end
         ST_CNT_RD: begin
         end
         ST_CNT_CHK: begin
            need_in = need_inc;
            cnt_in  = cnt_last_var ? '0 : CNT_W'(cnt_ff + 1'b1);
            if (cnt_last_var && need_full) begin
               res_status_in = STAT_FULL;
            end
         end
         ST_RX_HDR: begin
            fl_we    = 1'b1;
            fl_addr  = oth_base;
            fl_wdata = HDR_RECEIVE;
         end
         ST_NEW_ENTRY: begin
            fl_we    = 1'b1;
            fl_addr  = oth_base + FA_W'(1);
            fl_wdata = {16'(addr_ff), data_ff};
            mp_we    = 1'b1;
            mp_addr  = VAR_W'(addr_ff);
            mp_wdata = SLOT_W'(1);
            slot_in  = SLOT_W'(2);
            cnt_in   = '0;
         end
         ST_CP_RD: begin
         end
         ST_CP_CHK: begin
            if (map_hit && !cnt_is_a) begin
               fl_addr = act_base + FA_W'(mp_rdata);
            end else begin
               cnt_in = cnt_last_var ? '0 : CNT_W'(cnt_ff + 1'b1);
            end
         end
         ST_CP_WR: begin
            fl_we    = 1'b1;
            fl_addr  = oth_base + FA_W'(slot_ff);
            fl_wdata = {16'(cnt_ff), fl_rdata[DATA_W-1:0]};
            mp_we    = 1'b1;
            mp_wdata = slot_ff;
            slot_in  = slot_inc;
            cnt_in   = cnt_last_var ? '0 : CNT_W'(cnt_ff + 1'b1);
         end
         ST_ERASE: begin
            fl_we   = 1'b1;
            fl_addr = act_base + FA_W'(cnt_ff[SLOT_W-1:0]);
            cnt_in  = CNT_W'(cnt_ff + 1'b1);
         end
         ST_VALID_HDR: begin
            fl_we         = 1'b1;
            fl_addr       = oth_base;
            fl_wdata      = HDR_VALID;
            act_in        = !act_ff;
            res_status_in = STAT_DONE;
         end
         ST_DONE: begin
            if (rsp_load) begin
               rsp_data_in   = res_data_ff;
               rsp_status_in = res_status_ff;
            end
         end
         default: begin
         end
      endcase
   end

   assign rsp_valid_in = rsp_load || (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_FORMAT;
         cnt_ff       <= '0;
         act_ff       <= 1'b0;
         slot_ff      <= SLOT_W'(1);
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         act_ff       <= act_in;
         slot_ff      <= slot_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      need_ff       <= need_in;
      addr_ff       <= addr_in;
      data_ff       <= data_in;
      res_data_ff   <= res_data_in;
      res_status_ff <= res_status_in;
      rsp_data_ff   <= rsp_data_in;
      rsp_status_ff <= rsp_status_in;
   end

   `FEE_ASSERT_ALWAYS(a_format_after_reset, clock, reset |=> state_ff == ST_FORMAT, "store is not formatted after reset")
   `FEE_ASSERT(a_rsp_from_done, clock, reset, $rose(rsp_valid_ff) |-> $past(state_ff == ST_DONE), "response beat raised outside the done state")
   `FEE_ASSERT(a_copy_fits, clock, reset, state_ff == ST_CP_WR |-> slot_ff != '0, "compaction copy runs past the end of the page")
   `FEE_ASSERT(a_status_code, clock, reset, rsp_valid_ff |-> rsp_status_ff <= STAT_FULL, "response beat carries an unknown status code")

endmodule

// ===== design/fee_ram.sv =====
// ----------------------------------------------------------------------------
// Flash EEPROM emulation RAM
// Single-port synchronous RAM with one shared address and a registered read.
// ----------------------------------------------------------------------------
module fee_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wr_data,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[addr] <= wr_data;
      end
      rd_data <= mem[addr];
   end

endmodule
